[sv/rfrf_pkg.sv]
// Package: shared types and codes for the radio frame receive filter.
`default_nettype none
package rfrf_pkg;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_LEN_LO,
      PH_DST_HI,
      PH_DST_LO,
      PH_SRC_HI,
      PH_SRC_LO,
      PH_SERVICE,
      PH_CHECK,
      PH_RX
   } phase_type;

   localparam logic [2:0] EV_HEADER  = 3'd0;
   localparam logic [2:0] EV_START   = 3'd1;
   localparam logic [2:0] EV_PAYLOAD = 3'd2;
   localparam logic [2:0] EV_LAST    = 3'd3;
   localparam logic [2:0] EV_DROP    = 3'd4;

   localparam logic [2:0] DR_NONE     = 3'd0;
   localparam logic [2:0] DR_OVERSIZE = 3'd1;
   localparam logic [2:0] DR_ADDRESS  = 3'd2;
   localparam logic [2:0] DR_CHECKSUM = 3'd3;
   localparam logic [2:0] DR_SPACE    = 3'd4;
   localparam logic [2:0] DR_ENDED    = 3'd5;

   localparam logic [1:0] CSR_OWN_ADDRESS  = 2'd0;
   localparam logic [1:0] CSR_GROUP_MEMBER = 2'd1;
   localparam logic [1:0] CSR_SERVICE_EN   = 2'd2;

   localparam int          GROUP_FLAG_BIT = 15;
   localparam logic [15:0] BCAST_ADDR     = 16'hFFFF;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       transfer_end;
      logic       space_available;
   } item_type;

   typedef struct packed {
      logic        valid;
      item_type    item;
   } queue_head_type;

   typedef struct packed {
      logic [15:0] own_address;
      logic [14:0] group_membership;
      logic        service_byte_enable;
   } cfg_type;

   typedef struct packed {
      logic        keep_receiving;
      logic [2:0]  event_res;
      logic [2:0]  drop_reason;
      logic [8:0]  frame_length;
      logic [15:0] dest_address;
      logic [15:0] source_address;
      logic [7:0]  service_id;
      logic [7:0]  payload_byte;
   } result_type;

endpackage
`default_nettype wire

[sv/radio_frame_receive_filter.sv]
// Top level: radio frame receive filter with configuration registers.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid/req_ready, rx byte, end, space | in
//  rsp     | rsp_valid/rsp_ready, one result per byte  | out
//  csr     | csr_we, csr_index, csr_wdata              | in
//
// One byte per cycle sustained while rsp_ready stays high; each byte passes a queue slot,
// then the parser into the result register, before rsp_valid rises.
// While a result waits on rsp_ready the two-entry queue fills, then req_ready
// drops until the result is taken.
// Synchronous reset clears parser state, queue and configuration registers to zero/idle.
`default_nettype none
module radio_frame_receive_filter #(
   parameter int MAX_FRAME_LEN = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_transfer_end,
   input  wire logic        req_space_available,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_keep_receiving,
   output logic [2:0]       rsp_event_res,
   output logic [2:0]       rsp_drop_reason,
   output logic [8:0]       rsp_frame_length,
   output logic [15:0]      rsp_dest_address,
   output logic [15:0]      rsp_source_address,
   output logic [7:0]       rsp_service_id,
   output logic [7:0]       rsp_payload_byte,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   rfrf_pkg::cfg_type        cfg_ff;
   rfrf_pkg::item_type       in_item;
   rfrf_pkg::queue_head_type head;
   rfrf_pkg::result_type     result;
   logic                     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rfrf_pkg::CSR_OWN_ADDRESS:  cfg_ff.own_address         <= csr_wdata;
            rfrf_pkg::CSR_GROUP_MEMBER: cfg_ff.group_membership    <= csr_wdata[14:0];
            rfrf_pkg::CSR_SERVICE_EN:   cfg_ff.service_byte_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign in_item.rx_byte         = req_rx_byte;
   assign in_item.transfer_end    = req_transfer_end;
   assign in_item.space_available = req_space_available;

   rfrf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_item  (in_item),
      .head     (head),
      .pop      (pop)
   );

   rfrf_parse #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (result)
   );

   assign rsp_keep_receiving = result.keep_receiving;
   assign rsp_event_res      = result.event_res;
   assign rsp_drop_reason    = result.drop_reason;
   assign rsp_frame_length   = result.frame_length;
   assign rsp_dest_address   = result.dest_address;
   assign rsp_source_address = result.source_address;
   assign rsp_service_id     = result.service_id;
   assign rsp_payload_byte   = result.payload_byte;

endmodule
`default_nettype wire

[sv/rfrf_queue.sv]
// Front end: accepts received bytes into a two-entry queue.
`default_nettype none
module rfrf_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire rfrf_pkg::item_type       in_item,
   output rfrf_pkg::queue_head_type      head,
   input  wire logic                     pop
);

   rfrf_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       do_pop;

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign do_pop   = pop && (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

[sv/rfrf_parse.sv]
// Back end: header parser, frame filter and result register.
`default_nettype none
module rfrf_parse #(
   parameter int MAX_FRAME_LEN = 256
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rfrf_pkg::cfg_type        cfg,
   input  wire rfrf_pkg::queue_head_type head,
   output logic                          pop,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output rfrf_pkg::result_type          out_data
);

   localparam logic [15:0] MaxLen = 16'(MAX_FRAME_LEN);

   rfrf_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] dest_ff, dest_in;
   logic [15:0] source_ff, source_in;
   logic [7:0]  service_ff, service_in;
   logic [15:0] left_ff, left_in;

   logic                 out_valid_ff, out_valid_in;
   rfrf_pkg::result_type out_data_ff, out_data_in;

   logic       fire;
   logic [7:0] b;
   logic [7:0] sum_add;
   logic [2:0] content_reason;
   logic [2:0] reason;
   logic       done;
   logic       group_hit;
   logic       unicast_miss;
   logic [15:0] dest_full;

   assign fire = head.valid && (!out_valid_ff || out_ready);
   assign pop  = fire;
   assign b    = head.item.rx_byte;
   assign sum_add   = sum_ff + b;
   assign dest_full = {dest_ff[15:8], b};
   assign group_hit = (dest_full & {1'b0, cfg.group_membership}) != 16'd0;
   assign unicast_miss = (dest_full != cfg.own_address) && (dest_full != rfrf_pkg::BCAST_ADDR);

   // per-byte content check and frame completion
   always_comb begin
      content_reason = rfrf_pkg::DR_NONE;
      done           = 1'b0;
      unique case (phase_ff)
         rfrf_pkg::PH_LEN_LO: begin
            if ({length_ff[15:8], b} > MaxLen) content_reason = rfrf_pkg::DR_OVERSIZE;
         end
         rfrf_pkg::PH_DST_LO: begin
            if (dest_full[rfrf_pkg::GROUP_FLAG_BIT]) begin
               if (!group_hit) content_reason = rfrf_pkg::DR_ADDRESS;
            end else if (unicast_miss) begin
               content_reason = rfrf_pkg::DR_ADDRESS;
            end
         end
         rfrf_pkg::PH_CHECK: begin
            if (sum_ff != b) begin
               content_reason = rfrf_pkg::DR_CHECKSUM;
            end else if (!head.item.space_available) begin
               content_reason = rfrf_pkg::DR_SPACE;
            end else begin
               done = (length_ff == 16'd0);
            end
         end
         rfrf_pkg::PH_RX: begin
            done = (left_ff[15:1] == 15'd0);
         end
         default: begin
         end
      endcase
      reason = content_reason;
      if (content_reason == rfrf_pkg::DR_NONE && !done && head.item.transfer_end) begin
         reason = rfrf_pkg::DR_ENDED;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         unique case (phase_ff)
            rfrf_pkg::PH_LEN_LO:  phase_in = rfrf_pkg::PH_DST_HI;
            rfrf_pkg::PH_DST_HI:  phase_in = rfrf_pkg::PH_DST_LO;
            rfrf_pkg::PH_DST_LO:  phase_in = rfrf_pkg::PH_SRC_HI;
            rfrf_pkg::PH_SRC_HI:  phase_in = rfrf_pkg::PH_SRC_LO;
            rfrf_pkg::PH_SRC_LO:  phase_in = cfg.service_byte_enable ? rfrf_pkg::PH_SERVICE
                                                                     : rfrf_pkg::PH_CHECK;
            rfrf_pkg::PH_SERVICE: phase_in = rfrf_pkg::PH_CHECK;
            rfrf_pkg::PH_CHECK:   phase_in = rfrf_pkg::PH_RX;
            rfrf_pkg::PH_RX:      phase_in = rfrf_pkg::PH_RX;
            default:              phase_in = rfrf_pkg::PH_LEN_LO;
         endcase
         if (reason != rfrf_pkg::DR_NONE || done) begin
            phase_in = rfrf_pkg::PH_IDLE;
         end
      end
   end

   // header registers and result
   always_comb begin
      sum_in     = sum_ff;
      length_in  = length_ff;
      dest_in    = dest_ff;
      source_in  = source_ff;
      service_in = service_ff;
      left_in    = left_ff;

      out_data_in                = '0;
      out_data_in.event_res      = rfrf_pkg::EV_HEADER;
      out_data_in.drop_reason    = reason;
      out_data_in.keep_receiving = (phase_in != rfrf_pkg::PH_IDLE);

      unique case (phase_ff)
         rfrf_pkg::PH_LEN_LO: begin
            length_in = {length_ff[15:8], b};
            sum_in    = sum_add;
         end
         rfrf_pkg::PH_DST_HI: begin
            dest_in = {b, 8'h00};
            sum_in  = sum_add;
         end
         rfrf_pkg::PH_DST_LO: begin
            dest_in = dest_full;
            sum_in  = sum_add;
         end
         rfrf_pkg::PH_SRC_HI: begin
            source_in = {b, 8'h00};
            sum_in    = sum_add;
         end
         rfrf_pkg::PH_SRC_LO: begin
            source_in = {source_ff[15:8], b};
            sum_in    = sum_add;
         end
         rfrf_pkg::PH_SERVICE: begin
            service_in = b;
            sum_in     = sum_add;
         end
         rfrf_pkg::PH_CHECK: begin
            if (content_reason == rfrf_pkg::DR_NONE) begin
               left_in                    = length_ff;
               out_data_in.event_res      = rfrf_pkg::EV_START;
               out_data_in.frame_length   = length_ff[8:0];
               out_data_in.dest_address   = dest_ff;
               out_data_in.source_address = source_ff;
               out_data_in.service_id     = service_ff;
            end
         end
         rfrf_pkg::PH_RX: begin
            out_data_in.payload_byte = b;
            if (done) begin
               left_in               = 16'd0;
               out_data_in.event_res = rfrf_pkg::EV_LAST;
            end else begin
               left_in               = left_ff - 16'd1;
               out_data_in.event_res = rfrf_pkg::EV_PAYLOAD;
            end
         end
         default: begin
            // idle: high length byte opens a new header
            length_in  = {b, 8'h00};
            dest_in    = 16'd0;
            source_in  = 16'd0;
            service_in = 8'd0;
            sum_in     = b;
         end
      endcase

      if (reason != rfrf_pkg::DR_NONE) begin
         out_data_in.event_res      = rfrf_pkg::EV_DROP;
         out_data_in.frame_length   = '0;
         out_data_in.dest_address   = '0;
         out_data_in.source_address = '0;
         out_data_in.service_id     = '0;
         out_data_in.payload_byte   = '0;
      end

      out_valid_in = fire || (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rfrf_pkg::PH_IDLE;
         sum_ff       <= 8'd0;
         length_ff    <= 16'd0;
         dest_ff      <= 16'd0;
         source_ff    <= 16'd0;
         service_ff   <= 8'd0;
         left_ff      <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            sum_ff     <= sum_in;
            length_ff  <= length_in;
            dest_ff    <= dest_in;
            source_ff  <= source_in;
            service_ff <= service_in;
            left_ff    <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
`default_nettype wire

[bench/tb_radio_frame_receive_filter.sv]
// Testbench for the radio frame receive filter: directed table, then random frames.
`timescale 1ns / 100ps
module tb_radio_frame_receive_filter;

   localparam int MAX_LEN     = 256;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [7:0]           rx;
      logic                 te;
      logic                 sp;
      logic                 typed;
      rfrf_pkg::result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_transfer_end = 1'b0;
   logic        req_space_available = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_keep_receiving;
   logic [2:0]  rsp_event_res;
   logic [2:0]  rsp_drop_reason;
   logic [8:0]  rsp_frame_length;
   logic [15:0] rsp_dest_address;
   logic [15:0] rsp_source_address;
   logic [7:0]  rsp_service_id;
   logic [7:0]  rsp_payload_byte;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = rfrf_pkg::CSR_OWN_ADDRESS;
   logic [15:0] csr_wdata = 16'h0000;

   radio_frame_receive_filter #(.MAX_FRAME_LEN(MAX_LEN)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state and register copies
   rfrf_pkg::phase_type cur_phase = rfrf_pkg::PH_IDLE;
   logic [7:0]  hdr_sum   = 8'h00;
   logic [15:0] hdr_len   = 16'h0000;
   logic [15:0] hdr_dst   = 16'h0000;
   logic [15:0] hdr_src   = 16'h0000;
   logic [7:0]  hdr_svc   = 8'h00;
   logic [15:0] left_cnt  = 16'h0000;
   logic [15:0] cfg_own   = 16'h0000;
   logic [14:0] cfg_group = 15'h0000;
   logic        cfg_svc   = 1'b0;

   rfrf_pkg::result_type results_due[$];
   rfrf_pkg::result_type rsp_seen;
   rfrf_pkg::result_type rsp_due;
   int errors = 0;
   int cycles = 0;
   int bytes_sent = 0;
   int frames_started = 0;
   int payload_seen = 0;
   int settings_done = 0;
   int drops_by_reason [0:7] = '{default: 0};
   int tx_calm = 0;
   int rx_calm = 0;
   int rx_hold = 0;

   assign rsp_seen = {rsp_keep_receiving, rsp_event_res, rsp_drop_reason, rsp_frame_length,
                      rsp_dest_address, rsp_source_address, rsp_service_id, rsp_payload_byte};

   // random wait, with occasional runs of back-to-back transfers
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0)
         calm = $urandom_range(10, 40);
      return $urandom_range(0, 13);
   endfunction

   function automatic rfrf_pkg::result_type predict_filter(input logic [7:0] rx,
                                                           input logic te,
                                                           input logic sp);
      rfrf_pkg::result_type r;
      logic [2:0]          why;
      logic                done;
      rfrf_pkg::phase_type nxt;
      r = '0;
      r.event_res = rfrf_pkg::EV_HEADER;
      why = rfrf_pkg::DR_NONE;
      done = 1'b0;
      nxt = cur_phase;
      case (cur_phase)
         rfrf_pkg::PH_LEN_LO: begin
            hdr_len = hdr_len | {8'h00, rx};
            hdr_sum = hdr_sum + rx;
            if (hdr_len > MAX_LEN)
               why = rfrf_pkg::DR_OVERSIZE;
            nxt = rfrf_pkg::PH_DST_HI;
         end
         rfrf_pkg::PH_DST_HI: begin
            hdr_dst = {rx, 8'h00};
            hdr_sum = hdr_sum + rx;
            nxt = rfrf_pkg::PH_DST_LO;
         end
         rfrf_pkg::PH_DST_LO: begin
            hdr_dst = hdr_dst | {8'h00, rx};
            hdr_sum = hdr_sum + rx;
            if (hdr_dst[rfrf_pkg::GROUP_FLAG_BIT]) begin
               if ((hdr_dst[14:0] & cfg_group) == 15'h0000)
                  why = rfrf_pkg::DR_ADDRESS;
            end else if (hdr_dst != cfg_own && hdr_dst != rfrf_pkg::BCAST_ADDR) begin
               why = rfrf_pkg::DR_ADDRESS;
            end
            nxt = rfrf_pkg::PH_SRC_HI;
         end
         rfrf_pkg::PH_SRC_HI: begin
            hdr_src = {rx, 8'h00};
            hdr_sum = hdr_sum + rx;
            nxt = rfrf_pkg::PH_SRC_LO;
         end
         rfrf_pkg::PH_SRC_LO: begin
            hdr_src = hdr_src | {8'h00, rx};
            hdr_sum = hdr_sum + rx;
            nxt = cfg_svc ? rfrf_pkg::PH_SERVICE : rfrf_pkg::PH_CHECK;
         end
         rfrf_pkg::PH_SERVICE: begin
            hdr_svc = rx;
            hdr_sum = hdr_sum + rx;
            nxt = rfrf_pkg::PH_CHECK;
         end
         rfrf_pkg::PH_CHECK: begin
            if (hdr_sum != rx) begin
               why = rfrf_pkg::DR_CHECKSUM;
            end else if (!sp) begin
               why = rfrf_pkg::DR_SPACE;
            end else begin
               r.event_res = rfrf_pkg::EV_START;
               r.frame_length = hdr_len[8:0];
               r.dest_address = hdr_dst;
               r.source_address = hdr_src;
               r.service_id = hdr_svc;
               left_cnt = hdr_len;
               done = (hdr_len == 16'h0000);
               nxt = rfrf_pkg::PH_RX;
            end
         end
         rfrf_pkg::PH_RX: begin
            r.payload_byte = rx;
            if (left_cnt <= 16'd1) begin
               left_cnt = 16'h0000;
               r.event_res = rfrf_pkg::EV_LAST;
               done = 1'b1;
            end else begin
               left_cnt = left_cnt - 16'd1;
               r.event_res = rfrf_pkg::EV_PAYLOAD;
            end
         end
         default: begin
            hdr_len = {rx, 8'h00};
            hdr_dst = 16'h0000;
            hdr_src = 16'h0000;
            hdr_svc = 8'h00;
            hdr_sum = rx;
            nxt = rfrf_pkg::PH_LEN_LO;
         end
      endcase
      // a content drop wins over end of transfer; a completed frame ignores it
      if (why == rfrf_pkg::DR_NONE && !done && te)
         why = rfrf_pkg::DR_ENDED;
      if (why != rfrf_pkg::DR_NONE) begin
         r = '0;
         r.event_res = rfrf_pkg::EV_DROP;
         r.drop_reason = why;
         nxt = rfrf_pkg::PH_IDLE;
      end else if (done) begin
         nxt = rfrf_pkg::PH_IDLE;
      end
      cur_phase = nxt;
      r.keep_receiving = (cur_phase != rfrf_pkg::PH_IDLE);
      return r;
   endfunction

   function automatic rfrf_pkg::result_type hdr_res();
      rfrf_pkg::result_type r;
      r = '0;
      r.keep_receiving = 1'b1;
      r.event_res = rfrf_pkg::EV_HEADER;
      return r;
   endfunction

   function automatic rfrf_pkg::result_type drop_res(input logic [2:0] why);
      rfrf_pkg::result_type r;
      r = '0;
      r.event_res = rfrf_pkg::EV_DROP;
      r.drop_reason = why;
      return r;
   endfunction

   // one byte transfer; valid stays up across back-to-back bytes
   task automatic push_byte(input logic [7:0] rx, input logic te, input logic sp,
                            input logic typed, input rfrf_pkg::result_type fixed,
                            output rfrf_pkg::result_type r);
      int gap;
      gap = draw_wait(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      req_transfer_end <= te;
      req_space_available <= sp;
      do @(posedge clock); while (!req_ready);
      r = predict_filter(rx, te, sp);
      bytes_sent++;
      if (r.event_res == rfrf_pkg::EV_START)
         frames_started++;
      if (r.event_res == rfrf_pkg::EV_PAYLOAD || r.event_res == rfrf_pkg::EV_LAST)
         payload_seen++;
      if (r.event_res == rfrf_pkg::EV_DROP)
         drops_by_reason[r.drop_reason]++;
      results_due.push_back(typed ? fixed : r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] own, input logic [14:0] grp, input logic en);
      csr_we <= 1'b1;
      csr_index <= rfrf_pkg::CSR_OWN_ADDRESS;
      csr_wdata <= own;
      @(posedge clock);
      csr_index <= rfrf_pkg::CSR_GROUP_MEMBER;
      csr_wdata <= {1'($urandom_range(0, 1)), grp};
      @(posedge clock);
      csr_index <= rfrf_pkg::CSR_SERVICE_EN;
      csr_wdata <= {15'($urandom_range(0, 32767)), en};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_own = own;
      cfg_group = grp;
      cfg_svc = en;
      settings_done++;
   endtask

   task automatic send_frame();
      logic [7:0]  fb[$];
      logic [15:0] len;
      logic [15:0] dst;
      logic [14:0] hot;
      logic [7:0]  ck;
      logic        sp_ok;
      logic        te;
      logic        sp;
      rfrf_pkg::result_type r;
      int pick;
      int tend_at;
      int hdr_n;
      int i;
      // leave any half-parsed header behind first
      if (cur_phase != rfrf_pkg::PH_IDLE)
         push_byte(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)), 1'b0, '0, r);
      pick = $urandom_range(0, 199);
      if (pick < 3)
         len = 16'($urandom_range(250, 256));
      else if (pick < 12)
         len = 16'($urandom_range(257, 65535));
      else if (pick < 50)
         len = 16'h0000;
      else if (pick < 70)
         len = 16'($urandom_range(13, 40));
      else
         len = 16'($urandom_range(1, 12));
      hot = 15'd1 << $urandom_range(0, 14);
      pick = $urandom_range(0, 99);
      if (pick < 40)
         dst = cfg_own;
      else if (pick < 55)
         dst = rfrf_pkg::BCAST_ADDR;
      else if (pick < 75)
         dst = {1'b1, hot};
      else if (pick < 85)
         dst = {1'b1, 15'($urandom_range(0, 32767))};
      else
         dst = 16'($urandom_range(0, 65535));
      fb.push_back(len[15:8]);
      fb.push_back(len[7:0]);
      fb.push_back(dst[15:8]);
      fb.push_back(dst[7:0]);
      fb.push_back(8'($urandom_range(0, 255)));
      fb.push_back(8'($urandom_range(0, 255)));
      if (cfg_svc)
         fb.push_back(8'($urandom_range(0, 255)));
      ck = 8'h00;
      foreach (fb[k])
         ck = ck + fb[k];
      if ($urandom_range(0, 11) == 0)
         ck = ck ^ 8'($urandom_range(1, 255));
      fb.push_back(ck);
      hdr_n = fb.size();
      if (len <= MAX_LEN)
         repeat (len) fb.push_back(8'($urandom_range(0, 255)));
      sp_ok = ($urandom_range(0, 11) != 0);
      tend_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, fb.size() - 1) : -1;
      for (i = 0; i < fb.size(); i++) begin
         te = (i == tend_at) || (i == fb.size() - 1 && $urandom_range(0, 1) == 1);
         sp = (i == hdr_n - 1) ? sp_ok : 1'($urandom_range(0, 1));
         push_byte(fb[i], te, sp, 1'b0, '0, r);
         if (!r.keep_receiving)
            break;
      end
   endtask

   task automatic send_noise();
      rfrf_pkg::result_type r;
      int n;
      n = $urandom_range(1, 6);
      repeat (n)
         push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0),
                   1'($urandom_range(0, 1)), 1'b0, '0, r);
   endtask

   task automatic run_traffic(input int n);
      int target;
      target = bytes_sent + n;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 6) == 0)
            send_noise();
         else
            send_frame();
      end
   endtask

   task automatic run_setting(input logic [15:0] own, input logic [14:0] grp, input logic en);
      drain();
      repeat (4) @(posedge clock);
      set_config(own, grp, en);
      run_traffic(75);
      // sender holds off until every result is back
      drain();
      run_traffic(75);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned seen);
      if (want != seen) begin
         errors++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
      end
   endtask

   // result side: random stalls on rsp_ready, check each transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_hold = 0;
      end else if (rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            errors++;
            $display("%0t ns: result with nothing expected, got event %0d reason %0d",
                     $time, rsp_seen.event_res, rsp_seen.drop_reason);
         end else begin
            rsp_due = results_due.pop_front();
            check_field("keep_receiving", rsp_due.keep_receiving, rsp_seen.keep_receiving);
            check_field("event_res", rsp_due.event_res, rsp_seen.event_res);
            check_field("drop_reason", rsp_due.drop_reason, rsp_seen.drop_reason);
            check_field("frame_length", rsp_due.frame_length, rsp_seen.frame_length);
            check_field("dest_address", rsp_due.dest_address, rsp_seen.dest_address);
            check_field("source_address", rsp_due.source_address, rsp_seen.source_address);
            check_field("service_id", rsp_due.service_id, rsp_seen.service_id);
            check_field("payload_byte", rsp_due.payload_byte, rsp_seen.payload_byte);
         end
         rx_hold = draw_wait(rx_calm);
         if (rx_hold > 0)
            rsp_ready <= 1'b0;
      end else if (!rsp_ready) begin
         if (rx_hold <= 1)
            rsp_ready <= 1'b1;
         else
            rx_hold--;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  results_due.size());
         $display("tb_radio_frame_receive_filter NOT OK");
         $finish;
      end
   end

   initial begin
      stim_row_type         dir_rows[$];
      rfrf_pkg::result_type r;
      rfrf_pkg::result_type start0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: own address 0, no groups, no service byte
      start0 = '0;
      start0.event_res = rfrf_pkg::EV_START;
      start0.source_address = 16'hFFFF;
      // length 0xFFFF is oversize
      dir_rows.push_back('{8'hFF, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'hFF, 1'b0, 1'b1, 1'b1, drop_res(rfrf_pkg::DR_OVERSIZE)});
      // transfer ends on the first header byte
      dir_rows.push_back('{8'h01, 1'b1, 1'b0, 1'b1, drop_res(rfrf_pkg::DR_ENDED)});
      // broadcast with no group membership
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'h01, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'hFF, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'hFF, 1'b0, 1'b0, 1'b1, drop_res(rfrf_pkg::DR_ADDRESS)});
      // zero-length frame, transfer end on checksum still completes
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'hFF, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'hFF, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'hFE, 1'b1, 1'b1, 1'b1, start0});
      // one-byte frame, last payload byte with transfer end
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{8'h01, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{8'h12, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{8'h34, 1'b0, 1'b0, 1'b0, '0});
      dir_rows.push_back('{8'h47, 1'b0, 1'b1, 1'b0, '0});
      dir_rows.push_back('{8'hA5, 1'b1, 1'b0, 1'b0, '0});
      // bad checksum and no space together: checksum reported
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'h02, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b1, hdr_res()});
      dir_rows.push_back('{8'h01, 1'b0, 1'b0, 1'b1, drop_res(rfrf_pkg::DR_CHECKSUM)});
      foreach (dir_rows[k])
         push_byte(dir_rows[k].rx, dir_rows[k].te, dir_rows[k].sp, dir_rows[k].typed,
                   dir_rows[k].want, r);

      run_setting(16'h1234, 15'h0001, 1'b1);
      run_setting(16'hFFFF, 15'h7FFF, 1'b0);
      run_setting(16'h0000, 15'h0000, 1'b1);
      run_setting(16'h7FFF, 15'h4000, 1'b0);
      run_setting(16'($urandom_range(0, 65535)), 15'($urandom_range(0, 32767)),
                  1'($urandom_range(0, 1)));
      run_setting(16'($urandom_range(0, 65535)), 15'($urandom_range(0, 32767)),
                  1'($urandom_range(0, 1)));

      drain();
      repeat (8) @(posedge clock);
      $display("%0d byte transfers over %0d register settings, %0d frames accepted, %0d payload",
               bytes_sent, settings_done, frames_started, payload_seen);
      $display("drops: oversize %0d, address %0d, checksum %0d, no space %0d, ended %0d",
               drops_by_reason[rfrf_pkg::DR_OVERSIZE], drops_by_reason[rfrf_pkg::DR_ADDRESS],
               drops_by_reason[rfrf_pkg::DR_CHECKSUM], drops_by_reason[rfrf_pkg::DR_SPACE],
               drops_by_reason[rfrf_pkg::DR_ENDED]);
      if (errors == 0)
         $display("tb_radio_frame_receive_filter OK");
      else
         $display("tb_radio_frame_receive_filter NOT OK");
      $finish;
   end

endmodule

[filelist.f]
sv/rfrf_pkg.sv
sv/rfrf_queue.sv
sv/rfrf_parse.sv
sv/radio_frame_receive_filter.sv
bench/tb_radio_frame_receive_filter.sv
